/* sv/htbd_pkg.sv */
// htbd_pkg: shared types and constants for the Huffman tree build and decode block.
// Used by htbd_min2, htbd_out and huffman_tree_build_decode; depends on nothing.
`default_nettype none
package htbd_pkg;

	localparam int MAX_SYMBOLS_DEF = 64;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int LEAF_W_BITS     = 16;
	localparam int SYM_BITS        = 8;
	localparam int CNT_BITS        = 7;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_BIT  = 1'b1;

	localparam logic KIND_SYMBOL = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUILD_INIT,
		ST_SCAN,
		ST_MERGE,
		ST_RD_CHILD,
		ST_EMIT_SYM,
		ST_EMIT_END
	} st_t;

	typedef struct packed {
		logic clear;
		logic sample;
	} scan_ctl_t;

	typedef struct packed {
		logic                kind;
		logic [SYM_BITS-1:0] symbol;
		logic                err;
		logic                last;
	} res_t;

endpackage
`default_nettype wire

/* sv/huffman_tree_build_decode.sv */
// huffman_tree_build_decode: top level, sequencer, node memories and decode walk.
// Depends on htbd_pkg, htbd_min2 and htbd_out.
//
// Leaf loads are accepted one beat per cycle while the block is idle. The load that completes
// the count starts the build: a set-up state, then n-1 merges, each a scan of nodes 1..m (m
// nodes made so far) through the weight memory read port and the shared compare unit. A code
// bit beat walks at most one branch through the child memory, then loads each result beat it
// makes into the output register, waiting there while the consumer stalls. symbol_count is
// written through cfg_we/cfg_wdata.
`default_nettype none
module huffman_tree_build_decode
	import htbd_pkg::*;
#(
	parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CNT_BITS-1:0]    cfg_wdata,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   operation,
	input  wire logic [LEAF_W_BITS-1:0] leaf_weight,
	input  wire logic [SYM_BITS-1:0]    leaf_symbol,
	input  wire logic                   code_bit,
	input  wire logic                   string_end,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        result_kind,
	output logic      [SYM_BITS-1:0]    decoded_symbol,
	output logic                        string_error,
	output logic                        last_result
);

	localparam int NS  = 2 * MAX_SYMBOLS;
	localparam int IW  = $clog2(NS);
	localparam int CIW = $clog2(MAX_SYMBOLS);
	localparam int CW  = $clog2(MAX_SYMBOLS + 1);
	localparam int NW  = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
	localparam int LW  = (WEIGHT_BITS < LEAF_W_BITS) ? WEIGHT_BITS : LEAF_W_BITS;

	st_t st_q, st_d;

	logic [CNT_BITS-1:0] cnt_q;
	logic [CW-1:0]       loaded_q;
	logic                tree_q;
	logic [IW-1:0]       root_q;
	logic [IW-1:0]       walk_q;
	logic                failed_q;
	logic [IW-1:0]       next_q;
	logic [IW:0]         scan_q;
	logic                bit_q, end_q;
	logic [NS-1:0]       pend_q;

	logic                vld_s1, pnd_s1;
	logic [IW-1:0]       idx_s1;
	logic [NW-1:0]       wrd_s1;

	logic [NW-1:0]       wmem [NS];
	logic [2*IW-1:0]     kmem [NS];
	logic [SYM_BITS-1:0] cmem [MAX_SYMBOLS];
	logic [2*IW-1:0]     kid_rd_q;
	logic [SYM_BITS-1:0] chr_rd_q;

	logic [CW-1:0]  n;
	logic [IW-1:0]  n_iw;
	logic [IW-1:0]  root_tgt;
	logic [CW-1:0]  ld_base, k_load;
	logic [IW-1:0]  k_merge;
	logic [IW-1:0]  child;
	logic           issuing;
	logic           accept;
	logic           slot_free;
	logic           out_ld;
	res_t           out_d;
	scan_ctl_t      sctl;
	logic [IW-1:0]  b1_idx, b2_idx;
	logic [NW-1:0]  b1_wgt, b2_wgt;
	logic           st_err;

	always_comb begin
		if (cnt_q == '0) begin
			n = CW'(1);
		end else if (32'(cnt_q) > MAX_SYMBOLS) begin
			n = CW'(MAX_SYMBOLS);
		end else begin
			n = CW'(cnt_q);
		end
	end

	assign n_iw     = IW'(n);
	assign root_tgt = IW'({n_iw, 1'b0} - 1'b1);
	assign ld_base  = tree_q ? '0 : loaded_q;
	assign k_load   = ld_base + CW'(1);
	assign k_merge  = next_q + IW'(1);
	assign child    = bit_q ? kid_rd_q[IW-1:0] : kid_rd_q[2*IW-1:IW];
	assign issuing  = scan_q <= {1'b0, next_q};
	assign accept   = in_valid && in_ready;
	assign st_err   = failed_q || !tree_q || (walk_q != root_q);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_LOAD) begin
						if (k_load >= n) begin
							st_d = ST_BUILD_INIT;
						end
					end else if (tree_q && !failed_q && (walk_q > n_iw)) begin
						st_d = ST_RD_CHILD;
					end else if (string_end) begin
						st_d = ST_EMIT_END;
					end
				end
			end
			ST_BUILD_INIT: st_d = (n == CW'(1)) ? ST_IDLE : ST_SCAN;
			ST_SCAN: begin
				if (!issuing && !vld_s1) begin
					st_d = ST_MERGE;
				end
			end
			ST_MERGE: st_d = (k_merge == root_tgt) ? ST_IDLE : ST_SCAN;
			ST_RD_CHILD: begin
				if (child != '0 && child <= n_iw) begin
					st_d = ST_EMIT_SYM;
				end else if (end_q) begin
					st_d = ST_EMIT_END;
				end else begin
					st_d = ST_IDLE;
				end
			end
			ST_EMIT_SYM: begin
				if (slot_free) begin
					st_d = end_q ? ST_EMIT_END : ST_IDLE;
				end
			end
			ST_EMIT_END: begin
				if (slot_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		out_ld      = 1'b0;
		out_d       = '0;
		sctl.clear  = 1'b0;
		sctl.sample = vld_s1 && pnd_s1;
		unique case (st_q)
			ST_IDLE:       in_ready = 1'b1;
			ST_BUILD_INIT: sctl.clear = 1'b1;
			ST_SCAN:       ;
			ST_MERGE:      sctl.clear = 1'b1;
			ST_RD_CHILD:   ;
			ST_EMIT_SYM: begin
				out_ld      = slot_free;
				out_d.kind   = KIND_SYMBOL;
				out_d.symbol = chr_rd_q;
				out_d.err    = 1'b0;
				out_d.last   = !end_q;
			end
			ST_EMIT_END: begin
				out_ld      = slot_free;
				out_d.kind   = KIND_STATUS;
				out_d.symbol = '0;
				out_d.err    = st_err;
				out_d.last   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= CNT_BITS'(1);
			loaded_q <= '0;
			tree_q   <= 1'b0;
			root_q   <= '0;
			walk_q   <= '0;
			failed_q <= 1'b0;
			next_q   <= '0;
			scan_q   <= '0;
			vld_s1   <= 1'b0;
			pend_q   <= '0;
		end else begin
			st_q   <= st_d;
			vld_s1 <= (st_q == ST_SCAN) && issuing;
			if (cfg_we) begin
				cnt_q    <= cfg_wdata;
				loaded_q <= '0;
				tree_q   <= 1'b0;
				root_q   <= '0;
				walk_q   <= '0;
				failed_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_LOAD) begin
							loaded_q <= k_load;
							pend_q[IW'(k_load)] <= 1'b1;
							if (tree_q) begin
								tree_q   <= 1'b0;
								root_q   <= '0;
								walk_q   <= '0;
								failed_q <= 1'b0;
							end
						end else if (!tree_q) begin
							failed_q <= 1'b1;
						end else if (!failed_q && (walk_q <= n_iw)) begin
							failed_q <= 1'b1;
						end
					end
				end
				ST_BUILD_INIT: begin
					next_q <= n_iw;
					scan_q <= (IW+1)'(1);
					if (n == CW'(1)) begin
						tree_q   <= 1'b1;
						root_q   <= IW'(1);
						walk_q   <= IW'(1);
						failed_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						scan_q <= scan_q + (IW+1)'(1);
					end
				end
				ST_MERGE: begin
					pend_q[b1_idx]  <= 1'b0;
					pend_q[b2_idx]  <= 1'b0;
					pend_q[k_merge] <= 1'b1;
					next_q <= k_merge;
					scan_q <= (IW+1)'(1);
					if (k_merge == root_tgt) begin
						tree_q   <= 1'b1;
						root_q   <= k_merge;
						walk_q   <= k_merge;
						failed_q <= 1'b0;
					end
				end
				ST_RD_CHILD: begin
					if (child == '0) begin
						failed_q <= 1'b1;
					end else if (child <= n_iw) begin
						walk_q <= root_q;
					end else begin
						walk_q <= child;
					end
				end
				ST_EMIT_SYM: ;
				ST_EMIT_END: begin
					if (slot_free) begin
						walk_q   <= root_q;
						failed_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bit_q <= code_bit;
			end_q <= string_end;
		end
		idx_s1 <= scan_q[IW-1:0];
		pnd_s1 <= pend_q[scan_q[IW-1:0]];
		wrd_s1 <= wmem[scan_q[IW-1:0]];
		kid_rd_q <= kmem[walk_q];
		if (st_q == ST_RD_CHILD) begin
			chr_rd_q <= cmem[CIW'(child - IW'(1))];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && operation == OP_LOAD) begin
			wmem[IW'(k_load)] <= NW'(leaf_weight[LW-1:0]);
			cmem[CIW'(k_load - CW'(1))] <= leaf_symbol;
		end else if (st_q == ST_MERGE) begin
			wmem[k_merge] <= NW'(b1_wgt + b2_wgt);
			kmem[k_merge] <= {b1_idx, b2_idx};
		end
	end

	htbd_min2 #(
		.IW (IW),
		.NW (NW)
	) u_min2 (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sctl),
		.idx    (idx_s1),
		.wgt    (wrd_s1),
		.b1_idx (b1_idx),
		.b1_wgt (b1_wgt),
		.b2_idx (b2_idx),
		.b2_wgt (b2_wgt)
	);

	htbd_out u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.ld             (out_ld),
		.d              (out_d),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.result_kind    (result_kind),
		.decoded_symbol (decoded_symbol),
		.string_error   (string_error),
		.last_result    (last_result),
		.slot_free      (slot_free)
	);

endmodule
`default_nettype wire

/* sv/htbd_min2.sv */
// htbd_min2: shared compare unit that keeps the two lightest pending nodes seen in a scan.
// Nodes arrive in ascending number order, so a strict compare gives ties to the lower number.
// Depends on htbd_pkg.
`default_nettype none
module htbd_min2
	import htbd_pkg::*;
#(
	parameter int IW = 7,
	parameter int NW = 22
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire scan_ctl_t     ctl,
	input  wire logic [IW-1:0] idx,
	input  wire logic [NW-1:0] wgt,
	output logic      [IW-1:0] b1_idx,
	output logic      [NW-1:0] b1_wgt,
	output logic      [IW-1:0] b2_idx,
	output logic      [NW-1:0] b2_wgt
);

	logic          b1v_q, b2v_q;
	logic [IW-1:0] b1i_q, b2i_q;
	logic [NW-1:0] b1w_q, b2w_q;
	logic          lt1, lt2;

	assign lt1 = !b1v_q || (wgt < b1w_q);
	assign lt2 = !b2v_q || (wgt < b2w_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1v_q <= 1'b0;
			b2v_q <= 1'b0;
		end else if (ctl.clear) begin
			b1v_q <= 1'b0;
			b2v_q <= 1'b0;
		end else if (ctl.sample) begin
			if (lt1) begin
				b1v_q <= 1'b1;
				b2v_q <= b1v_q;
			end else if (lt2) begin
				b2v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear && ctl.sample) begin
			if (lt1) begin
				b1i_q <= idx;
				b1w_q <= wgt;
				b2i_q <= b1i_q;
				b2w_q <= b1w_q;
			end else if (lt2) begin
				b2i_q <= idx;
				b2w_q <= wgt;
			end
		end
	end

	assign b1_idx = b1i_q;
	assign b1_wgt = b1w_q;
	assign b2_idx = b2i_q;
	assign b2_wgt = b2w_q;

endmodule
`default_nettype wire

/* sv/htbd_out.sv */
// htbd_out: output register for result beats, freeing the sequencer from the consumer.
// Depends on htbd_pkg.
`default_nettype none
module htbd_out
	import htbd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                ld,
	input  wire res_t                d,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic                     result_kind,
	output logic      [SYM_BITS-1:0] decoded_symbol,
	output logic                     string_error,
	output logic                     last_result,
	output logic                     slot_free
);

	logic valid_q;
	res_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			data_q <= d;
		end
	end

	assign slot_free      = !valid_q || out_ready;
	assign out_valid      = valid_q;
	assign result_kind    = data_q.kind;
	assign decoded_symbol = data_q.symbol;
	assign string_error   = data_q.err;
	assign last_result    = data_q.last;

endmodule
`default_nettype wire

/* tb/huffman_decode_checker.sv */
// huffman_decode_checker: watches the config port and both channels of the Huffman
// tree build and decode block, predicts every result beat and compares it on arrival.
// Depends on htbd_pkg for widths, operation codes and the result struct.
module huffman_decode_checker
	import htbd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CNT_BITS-1:0]    cfg_wdata,
	input  wire logic                   in_valid,
	input  wire logic                   in_ready,
	input  wire logic                   operation,
	input  wire logic [LEAF_W_BITS-1:0] leaf_weight,
	input  wire logic [SYM_BITS-1:0]    leaf_symbol,
	input  wire logic                   code_bit,
	input  wire logic                   string_end,
	input  wire logic                   out_valid,
	input  wire logic                   out_ready,
	input  wire logic                   result_kind,
	input  wire logic [SYM_BITS-1:0]    decoded_symbol,
	input  wire logic                   string_error,
	input  wire logic                   last_result,
	output int                          mismatches,
	output int                          results_waiting
);

	localparam int NSYM      = MAX_SYMBOLS_DEF;
	localparam int SLOTS     = 2 * NSYM;
	localparam int NODE_BITS = $clog2(SLOTS);
	localparam int SUM_BITS  = WEIGHT_BITS_DEF + $clog2(NSYM);

	logic [CNT_BITS-1:0]  count_cfg = CNT_BITS'(1);
	logic [SUM_BITS-1:0]  node_sum [SLOTS];
	logic [NODE_BITS-1:0] left_of [SLOTS];
	logic [NODE_BITS-1:0] right_of [SLOTS];
	logic [SYM_BITS-1:0]  leaf_sym [NSYM+1];
	bit                   in_pool [SLOTS];
	int                   leaves_in;
	int                   top_node;
	int                   cursor;
	bit                   walk_dead;
	res_t                 results_due [$];
	res_t                 got;
	res_t                 want;
	int                   bad = 0;

	function automatic int leaf_total();
		int c;
		c = int'(count_cfg);
		if (c < 1) c = 1;
		if (c > NSYM) c = NSYM;
		return c;
	endfunction

	function automatic void drop_tree();
		for (int i = 0; i < SLOTS; i++) begin
			left_of[i] = '0;
			right_of[i] = '0;
			in_pool[i] = 1'b0;
		end
		leaves_in = 0;
		top_node = 0;
		cursor = 0;
		walk_dead = 1'b0;
	endfunction

	// lightest node in the pool, lower number wins a tie
	function automatic int take_lightest();
		int best;
		best = 0;
		for (int i = 1; i <= top_node && i < SLOTS; i++)
			if (in_pool[i] && (best == 0 || node_sum[i] < node_sum[best]))
				best = i;
		in_pool[best] = 1'b0;
		return best;
	endfunction

	function automatic void build_code_tree(input int n);
		int a;
		int b;
		for (int i = 1; i <= n; i++)
			in_pool[i] = 1'b1;
		top_node = n;
		for (int left = n; left >= 2; left--) begin
			a = take_lightest();
			b = take_lightest();
			top_node++;
			node_sum[top_node] = node_sum[a] + node_sum[b];
			left_of[top_node] = NODE_BITS'(a);
			right_of[top_node] = NODE_BITS'(b);
			in_pool[top_node] = 1'b1;
		end
		cursor = top_node;
		walk_dead = 1'b0;
	endfunction

	function automatic void queue_result(input logic kind, input logic [SYM_BITS-1:0] sym,
			input logic err, input logic last);
		res_t r;
		r.kind = kind;
		r.symbol = sym;
		r.err = err;
		r.last = last;
		results_due = {results_due, r};
	endfunction

	function automatic void decode_step(input logic op, input logic [LEAF_W_BITS-1:0] w,
			input logic [SYM_BITS-1:0] s, input logic b, input logic e);
		int n;
		int k;
		int child;
		n = leaf_total();
		if (op == OP_LOAD) begin
			if (top_node != 0)
				drop_tree();
			k = leaves_in + 1;
			node_sum[k] = SUM_BITS'(w);
			leaf_sym[k] = s;
			left_of[k] = '0;
			right_of[k] = '0;
			leaves_in = k;
			if (k >= n)
				build_code_tree(n);
		end else begin
			if (top_node == 0) begin
				walk_dead = 1'b1;
			end else if (!walk_dead) begin
				child = int'(b ? right_of[cursor] : left_of[cursor]);
				if (child == 0) begin
					walk_dead = 1'b1;
				end else begin
					cursor = child;
					if (child <= n) begin
						queue_result(KIND_SYMBOL, leaf_sym[child], 1'b0, !e);
						cursor = top_node;
					end
				end
			end
			if (e) begin
				queue_result(KIND_STATUS, '0,
					walk_dead || top_node == 0 || cursor != top_node, 1'b1);
				cursor = top_node;
				walk_dead = 1'b0;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg = CNT_BITS'(1);
			drop_tree();
			results_due.delete();
		end else begin
			if (cfg_we) begin
				count_cfg = cfg_wdata;
				drop_tree();
			end
			if (out_valid && out_ready) begin
				got.kind = result_kind;
				got.symbol = decoded_symbol;
				got.err = string_error;
				got.last = last_result;
				if (results_due.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("unexpected result beat: kind %0d sym %02h err %0d last %0d",
							got.kind, got.symbol, got.err, got.last);
				end else begin
					want = results_due.pop_front();
					if (got.kind !== want.kind || got.symbol !== want.symbol ||
							got.err !== want.err || got.last !== want.last) begin
						bad++;
						if (bad <= 10)
							$display("mismatch kind/sym/err/last: exp %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
								want.kind, want.symbol, want.err, want.last,
								got.kind, got.symbol, got.err, got.last);
					end
				end
			end
			if (in_valid && in_ready)
				decode_step(operation, leaf_weight, leaf_symbol, code_bit, string_end);
		end
		mismatches <= bad;
		results_waiting <= results_due.size();
	end

endmodule

/* tb/tb_huffman_tree_build_decode.sv */
// tb_huffman_tree_build_decode: drives leaf loads, code bits and symbol_count writes into
// the Huffman tree build and decode block and gives the verdict.
// Depends on htbd_pkg, huffman_tree_build_decode and huffman_decode_checker.
module tb_huffman_tree_build_decode;
	import htbd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CNT_BITS-1:0]    cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic                   operation;
	logic [LEAF_W_BITS-1:0] leaf_weight;
	logic [SYM_BITS-1:0]    leaf_symbol;
	logic                   code_bit;
	logic                   string_end;
	logic                   out_valid;
	logic                   out_ready;
	logic                   result_kind;
	logic [SYM_BITS-1:0]    decoded_symbol;
	logic                   string_error;
	logic                   last_result;

	int mismatches;
	int results_waiting;
	int cycles = 0;
	bit calm = 1'b0;
	int count_now = 1;
	int loads_done = 0;
	bit tree_up = 1'b0;
	logic [CNT_BITS-1:0] counts [14] = '{7'd0, 7'd127, 7'd2, 7'd5, 7'd64, 7'd1, 7'd3,
		7'd9, 7'd2, 7'd17, 7'd4, 7'd7, 7'd3, 7'd6};

	huffman_tree_build_decode i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.leaf_weight    (leaf_weight),
		.leaf_symbol    (leaf_symbol),
		.code_bit       (code_bit),
		.string_end     (string_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.decoded_symbol (decoded_symbol),
		.string_error   (string_error),
		.last_result    (last_result)
	);

	huffman_decode_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.leaf_weight     (leaf_weight),
		.leaf_symbol     (leaf_symbol),
		.code_bit        (code_bit),
		.string_end      (string_end),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.decoded_symbol  (decoded_symbol),
		.string_error    (string_error),
		.last_result     (last_result),
		.mismatches      (mismatches),
		.results_waiting (results_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		int w;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			w = calm ? 0 : $urandom_range(0, 11);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic logic [LEAF_W_BITS-1:0] pick_weight();
		case ($urandom_range(0, 3))
			0: return LEAF_W_BITS'($urandom);
			1: return LEAF_W_BITS'($urandom_range(0, 3));
			2: return $urandom_range(0, 1) ? '1 : '0;
			default: return LEAF_W_BITS'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send(input logic op, input logic [LEAF_W_BITS-1:0] w,
			input logic [SYM_BITS-1:0] s, input logic b, input logic e);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		leaf_weight <= w;
		leaf_symbol <= s;
		code_bit <= b;
		string_end <= e;
		do @(posedge clk); while (!in_ready);
		if (op == OP_LOAD) begin
			if (tree_up) begin
				tree_up = 1'b0;
				loads_done = 0;
			end
			loads_done++;
			if (loads_done >= count_now)
				tree_up = 1'b1;
		end
	endtask

	task automatic send_bit(input logic b, input logic e);
		send(OP_BIT, LEAF_W_BITS'($urandom), SYM_BITS'($urandom), b, e);
	endtask

	task automatic send_leaf(input logic [LEAF_W_BITS-1:0] w, input logic [SYM_BITS-1:0] s);
		send(OP_LOAD, w, s, 1'($urandom), 1'($urandom));
	endtask

	// only once the block has gone quiet; a build may still run after the last result
	task automatic write_count(input logic [CNT_BITS-1:0] v);
		int settle;
		in_valid <= 1'b0;
		do @(posedge clk); while (results_waiting != 0);
		settle = 2 * count_now * count_now + 64;
		repeat (settle) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_now = (v == 0) ? 1 : ((v > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : int'(v));
		loads_done = 0;
		tree_up = 1'b0;
	endtask

	task automatic run_phase(input logic [CNT_BITS-1:0] v, input int extra);
		int stray;
		int stop;
		calm = ($urandom_range(0, 3) == 0);
		write_count(v);
		stray = (count_now > 16) ? 199 : 29;
		stop = (count_now > 8) ? 7 : 3;
		for (int i = 0; i < count_now; i++)
			send_leaf(pick_weight(), SYM_BITS'($urandom));
		for (int i = 0; i < extra; i++) begin
			if (!tree_up) begin
				if ($urandom_range(0, 19) == 0)
					send_bit(1'($urandom), 1'($urandom));
				else
					send_leaf(pick_weight(), SYM_BITS'($urandom));
			end else if ($urandom_range(0, stray) == 0) begin
				send_leaf(pick_weight(), SYM_BITS'($urandom));
			end else begin
				send_bit(1'($urandom), $urandom_range(0, stop) == 0);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		operation <= OP_LOAD;
		leaf_weight <= '0;
		leaf_symbol <= '0;
		code_bit <= 1'b0;
		string_end <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// bits with no tree yet
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b1);
		// single leaf: every branch is missing
		write_count(CNT_BITS'(1));
		send_leaf('1, 8'hFF);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b1);
		// three equal weights, ties by node number
		write_count(CNT_BITS'(3));
		send_leaf('0, 8'h00);
		send_leaf('0, 8'hAA);
		send_leaf('0, 8'h55);
		send_bit(1'b0, 1'b1);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b1, 1'b1);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b1);
		// load over a built tree restarts the load
		send_leaf('1, 8'h12);
		send_bit(1'b0, 1'b1);
		send_leaf(16'h8000, 8'h34);
		send_leaf(16'h0001, 8'h56);
		send_bit(1'b1, 1'b0);
		send_bit(1'b0, 1'b1);
		send_bit(1'b1, 1'b1);

		foreach (counts[p])
			run_phase(counts[p], 45);

		in_valid <= 1'b0;
		do @(posedge clk); while (results_waiting != 0);
		repeat (2 * count_now * count_now + 64) @(posedge clk);
		if (mismatches == 0 && results_waiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
